// ===== rtl/ufl_pkg.sv =====
package ufl_pkg;

   // Fixed result and vector width; the payload structs are built on it.
   localparam int DATA_WIDTH            = 16;
   localparam int CORDIC_STAGES_DEFAULT = 14;
   localparam int MAX_STAGES            = 24;

   // cos and sin carry TRIG_FRAC fraction bits plus sign and one integer bit
   localparam int TRIG_FRAC    = 46 - DATA_WIDTH;
   localparam int TRIG_W       = TRIG_FRAC + 2;
   localparam int ANGLE_W      = 32;
   localparam int HEAD_W       = 16;
   localparam int COEF_W       = 16;
   localparam int PROD_W       = TRIG_W + DATA_WIDTH;
   localparam int TERM_W       = PROD_W + 1;
   localparam int MULT_W       = TERM_W + COEF_W + 1;
   localparam int ACC_W        = 64;
   localparam int COEF_SHIFT   = 12;
   localparam int RESULT_SHIFT = TRIG_FRAC + COEF_SHIFT;
   localparam int ROUND_W      = ACC_W - RESULT_SHIFT;

   localparam logic signed [HEAD_W:0] QUARTER_TURN = (HEAD_W + 1)'(16384);
   localparam logic signed [HEAD_W:0] HALF_TURN    = (HEAD_W + 1)'(32768);

   localparam logic [COEF_W-1:0] RADIUS_RESET     = COEF_W'(1229);
   localparam logic [COEF_W-1:0] INV_RADIUS_RESET = COEF_W'(13653);

   // CORDIC limit gain 0.6072529350 in Q40, rounded to TRIG_FRAC bits
   localparam longint GAIN_Q40  = 64'sd667681663058;
   localparam longint GAIN_TRIG =
      (GAIN_Q40 + (longint'(1) <<< (39 - TRIG_FRAC))) >>> (40 - TRIG_FRAC);
   localparam logic signed [TRIG_W-1:0] GAIN_INIT = TRIG_W'(GAIN_TRIG);

   localparam logic signed [ACC_W-1:0] ROUND_HALF =
      ACC_W'(longint'(1) <<< (RESULT_SHIFT - 1));
   localparam logic signed [DATA_WIDTH-1:0] RES_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] RES_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   typedef enum logic {
      OP_INVERSE = 1'b0,
      OP_FORWARD = 1'b1
   } opcode_type;

   typedef enum logic {
      CSR_RADIUS     = 1'b0,
      CSR_INV_RADIUS = 1'b1
   } csr_index_type;

   typedef struct packed {
      opcode_type                    opcode;
      logic signed [HEAD_W-1:0]      heading;
      logic signed [DATA_WIDTH-1:0]  vec_first;
      logic signed [DATA_WIDTH-1:0]  vec_second;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0]  res_first;
      logic signed [DATA_WIDTH-1:0]  res_second;
      logic                          clipped;
   } rsp_type;

   // One rotator slot: the rotating vector, residual angle and the item's sideband
   typedef struct packed {
      logic                          forward;
      logic                          flip;
      logic signed [DATA_WIDTH-1:0]  a1;
      logic signed [DATA_WIDTH-1:0]  a2;
      logic signed [TRIG_W-1:0]      x;
      logic signed [TRIG_W-1:0]      y;
      logic signed [ANGLE_W-1:0]     z;
   } cell_type;

   // atan(2^-i), 2^32 = 2*pi
   function automatic logic [ANGLE_W-1:0] atan_entry(input int stage);
      logic [ANGLE_W-1:0] value;
      unique case (stage)
         0:       value = 32'd536870912;
         1:       value = 32'd316933406;
         2:       value = 32'd167458907;
         3:       value = 32'd85004756;
         4:       value = 32'd42667331;
         5:       value = 32'd21354465;
         6:       value = 32'd10679838;
         7:       value = 32'd5340245;
         8:       value = 32'd2670163;
         9:       value = 32'd1335087;
         10:      value = 32'd667544;
         11:      value = 32'd333772;
         12:      value = 32'd166886;
         13:      value = 32'd83443;
         14:      value = 32'd41722;
         15:      value = 32'd20861;
         16:      value = 32'd10430;
         17:      value = 32'd5215;
         18:      value = 32'd2608;
         19:      value = 32'd1304;
         20:      value = 32'd652;
         21:      value = 32'd326;
         22:      value = 32'd163;
         23:      value = 32'd81;
         default: value = '0;
      endcase
      return value;
   endfunction

endpackage

// ===== rtl/ufl_cordic_cell.sv =====
module ufl_cordic_cell
   import ufl_pkg::*;
#(
   parameter int STAGE = 0
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     enable,
   input  logic     up_valid,
   input  cell_type up_cell,
   output logic     dn_valid,
   output cell_type dn_cell
);

   localparam logic signed [ANGLE_W-1:0] ATAN = $signed(atan_entry(STAGE));

   logic                     valid_ff;
   cell_type                 cell_ff;
   cell_type                 cell_in;
   logic signed [TRIG_W-1:0] dx;
   logic signed [TRIG_W-1:0] dy;

   // arithmetic shift floors, as the rotation needs
   assign dx = up_cell.y >>> STAGE;
   assign dy = up_cell.x >>> STAGE;

   always_comb begin
      cell_in = up_cell;
      if (!up_cell.z[ANGLE_W-1]) begin
         cell_in.x = up_cell.x - dx;
         cell_in.y = up_cell.y + dy;
         cell_in.z = up_cell.z - ATAN;
      end else begin
         cell_in.x = up_cell.x + dx;
         cell_in.y = up_cell.y - dy;
         cell_in.z = up_cell.z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         cell_ff <= cell_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_cell  = cell_ff;

endmodule

// ===== rtl/ufl_matrix.sv =====
module ufl_matrix
   import ufl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              up_valid,
   input  cell_type          up_cell,
   input  logic [COEF_W-1:0] radius,
   input  logic [COEF_W-1:0] inverse_radius,
   output logic              dn_valid,
   output rsp_type           dn_result
);

   // round half up, then clamp; returns {clip, value}
   function automatic logic [DATA_WIDTH:0] round_clamp(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0]   sum;
      logic signed [ROUND_W-1:0] rq;
      logic [ROUND_W-DATA_WIDTH:0] top;
      logic [DATA_WIDTH:0]       result;
      sum = acc + ROUND_HALF;
      rq  = sum[ACC_W-1:RESULT_SHIFT];
      top = rq[ROUND_W-1:DATA_WIDTH-1];
      if ((&top) || !(|top)) begin
         result = {1'b0, rq[DATA_WIDTH-1:0]};
      end else if (rq[ROUND_W-1]) begin
         result = {1'b1, RES_MIN};
      end else begin
         result = {1'b1, RES_MAX};
      end
      return result;
   endfunction

   // products stage
   logic                     p_valid_ff;
   logic                     p_forward_ff;
   logic signed [TRIG_W-1:0] cos_v;
   logic signed [TRIG_W-1:0] sin_v;
   logic signed [PROD_W-1:0] ca1_ff, sa2_ff, ca2_ff, sa1_ff;

   // operand select stage
   logic                     q_valid_ff;
   logic signed [ACC_W-1:0]  base1_ff, base2_ff, base1_in, base2_in;
   logic signed [TERM_W-1:0] m1_ff, m2_ff, m1_in, m2_in;
   logic [COEF_W-1:0]        k_ff;

   // accumulate stage
   logic                     a_valid_ff;
   logic signed [MULT_W-1:0] prod1, prod2;
   logic signed [ACC_W-1:0]  acc1_ff, acc2_ff;
   logic [DATA_WIDTH:0]      r1, r2;

   assign cos_v = up_cell.flip ? -up_cell.x : up_cell.x;
   assign sin_v = up_cell.flip ? -up_cell.y : up_cell.y;

   always_comb begin
      if (p_forward_ff) begin
         base1_in = $signed(ACC_W'(ca1_ff)) <<< COEF_SHIFT;
         base2_in = $signed(ACC_W'(sa1_ff)) <<< COEF_SHIFT;
         m1_in    = -$signed(TERM_W'(sa2_ff));
         m2_in    = $signed(TERM_W'(ca2_ff));
      end else begin
         base1_in = $signed(ACC_W'($signed(TERM_W'(ca1_ff)) + $signed(TERM_W'(sa2_ff))))
                    <<< COEF_SHIFT;
         base2_in = '0;
         m1_in    = '0;
         m2_in    = $signed(TERM_W'(ca2_ff)) - $signed(TERM_W'(sa1_ff));
      end
   end

   assign prod1 = m1_ff * $signed({1'b0, k_ff});
   assign prod2 = m2_ff * $signed({1'b0, k_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         q_valid_ff <= 1'b0;
         a_valid_ff <= 1'b0;
      end else if (enable) begin
         p_valid_ff <= up_valid;
         q_valid_ff <= p_valid_ff;
         a_valid_ff <= q_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         p_forward_ff <= up_cell.forward;
         ca1_ff       <= cos_v * up_cell.a1;
         sa2_ff       <= sin_v * up_cell.a2;
         ca2_ff       <= cos_v * up_cell.a2;
         sa1_ff       <= sin_v * up_cell.a1;
         base1_ff     <= base1_in;
         base2_ff     <= base2_in;
         m1_ff        <= m1_in;
         m2_ff        <= m2_in;
         k_ff         <= p_forward_ff ? radius : inverse_radius;
         acc1_ff      <= base1_ff + $signed(prod1[ACC_W-1:0]);
         acc2_ff      <= base2_ff + $signed(prod2[ACC_W-1:0]);
      end
   end

   assign r1 = round_clamp(acc1_ff);
   assign r2 = round_clamp(acc2_ff);

   assign dn_valid             = a_valid_ff;
   assign dn_result.res_first  = r1[DATA_WIDTH-1:0];
   assign dn_result.res_second = r2[DATA_WIDTH-1:0];
   assign dn_result.clipped    = r1[DATA_WIDTH] | r2[DATA_WIDTH];

endmodule

// ===== rtl/unicycle_feedback_linearization_core.sv =====
// Unicycle feedback linearization: per item, builds L(theta) = [[cos, -R sin],
// [sin, R cos]] and returns u = L^-1 v (opcode inverse) or y = L v (opcode
// forward), each component rounded to Q8.8 and saturated, with a clip flag.
// Channels: req_* takes one item (opcode, heading, two Q8.8 components);
// rsp_* returns exactly one result item per request, in order. Both are
// valid/ready. csr_* writes radius (index 0) and its reciprocal (index 1). The
// user writes only while no item is in flight; the block does not enforce it,
// nor check the two against each other. From request accept to response valid:
// fold register, one rotator cell per CORDIC stage, three matrix stages, output
// register. Throughput: one item per cycle while the skid register is empty;
// the rotator chain and matrix pipeline each hold one item per register rank.
// Stall: a skid register behind the output register catches the item in
// flight when the receiver holds rsp_ready low; the pipeline then freezes and
// req_ready drops until the skid drains. req_ready never depends on rsp_ready.
// Reset: empties the pipeline, output and skid registers, and restores radius
// 0.3 and reciprocal 1/0.3 in Q4.12.
module unicycle_feedback_linearization_core
   import ufl_pkg::*;
#(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_payload,
   input  logic                  csr_write,
   input  csr_index_type         csr_index,
   input  logic [COEF_W-1:0]     csr_wdata
);

   // configuration registers
   logic [COEF_W-1:0] radius_ff;
   logic [COEF_W-1:0] inv_radius_ff;

   // pipeline advance: hold everything while the skid register is occupied
   logic advance;

   // fold stage
   logic                     fold_valid_ff;
   cell_type                 fold_ff;
   cell_type                 fold_in;
   logic signed [HEAD_W:0]   head_ext;
   logic signed [HEAD_W:0]   folded;
   logic                     flip;

   // rotator chain: slot 0 is the fold register, slot CORDIC_STAGES the tail
   logic     chain_valid [0:CORDIC_STAGES];
   cell_type chain_cell  [0:CORDIC_STAGES];

   // matrix output
   logic    mat_valid;
   rsp_type mat_result;
   logic    incoming;

   // output and skid registers
   logic    out_valid_ff;
   rsp_type out_ff;
   logic    skid_valid_ff;
   rsp_type skid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff     <= RADIUS_RESET;
         inv_radius_ff <= INV_RADIUS_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_RADIUS:     radius_ff     <= csr_wdata;
            CSR_INV_RADIUS: inv_radius_ff <= csr_wdata;
            default:        radius_ff     <= radius_ff;
         endcase
      end
   end

   assign advance   = !skid_valid_ff;
   assign req_ready = advance;

   // Fold the heading into [-pi/2, pi/2] by a half turn; negate cos and sin later.
   assign head_ext = {req_payload.heading[HEAD_W-1], req_payload.heading};

   always_comb begin
      if (head_ext > QUARTER_TURN) begin
         folded = head_ext - HALF_TURN;
         flip   = 1'b1;
      end else if (head_ext < -QUARTER_TURN) begin
         folded = head_ext + HALF_TURN;
         flip   = 1'b1;
      end else begin
         folded = head_ext;
         flip   = 1'b0;
      end
   end

   always_comb begin
      fold_in.forward = (req_payload.opcode == OP_FORWARD);
      fold_in.flip    = flip;
      fold_in.a1      = req_payload.vec_first;
      fold_in.a2      = req_payload.vec_second;
      fold_in.x       = GAIN_INIT;
      fold_in.y       = '0;
      // binary angle scaled from 2^16 to 2^32 per full turn
      fold_in.z       = {folded[HEAD_W-1:0], {(ANGLE_W-HEAD_W){1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_valid_ff <= 1'b0;
      end else if (advance) begin
         fold_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fold_ff <= fold_in;
      end
   end

   assign chain_valid[0] = fold_valid_ff;
   assign chain_cell[0]  = fold_ff;

   // One rotation per cell; each cell hands its vector to the next every cycle in which the pipeline advances.
   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
      ufl_cordic_cell #(
         .STAGE (g)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (advance),
         .up_valid (chain_valid[g]),
         .up_cell  (chain_cell[g]),
         .dn_valid (chain_valid[g+1]),
         .dn_cell  (chain_cell[g+1])
      );
   end

   ufl_matrix u_matrix (
      .clock          (clock),
      .reset          (reset),
      .enable         (advance),
      .up_valid       (chain_valid[CORDIC_STAGES]),
      .up_cell        (chain_cell[CORDIC_STAGES]),
      .radius         (radius_ff),
      .inverse_radius (inv_radius_ff),
      .dn_valid       (mat_valid),
      .dn_result      (mat_result)
   );

   assign incoming = mat_valid && advance;

   // Output register with skid: drain the skid first, else load the new item;
   // park the new item in the skid when the output is stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= incoming;
         end
      end else if (incoming) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
         end else if (incoming) begin
            out_ff <= mat_result;
         end
      end else if (incoming) begin
         skid_ff <= mat_result;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   // The skid only ever holds an item behind a held output item.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register full while output register empty");

   // The skid fills only when the output register held a stalled item (valid, rsp_ready low) at the loading edge.
   a_skid_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && !rsp_ready))
      else $error("skid register loaded without an output stall");

   // The folded angle stays within a quarter turn either way.
   a_fold_range: assert property (@(posedge clock) disable iff (reset)
      fold_valid_ff |-> (fold_ff.z <= $signed(32'sh4000_0000) &&
                         fold_ff.z >= $signed(-32'sh4000_0000)))
      else $error("folded heading outside [-pi/2, pi/2]");

   // A clipped result has at least one component at a rail.
   a_clip_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.clipped) |->
         (rsp_payload.res_first == RES_MAX || rsp_payload.res_first == RES_MIN ||
          rsp_payload.res_second == RES_MAX || rsp_payload.res_second == RES_MIN))
      else $error("clip flag set with no saturated component");

endmodule

// ===== tb/ufl_result_checker.sv =====
module ufl_result_checker
   import ufl_pkg::*;
#(
   parameter int STAGES = CORDIC_STAGES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_type               req_payload,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_type               rsp_payload,
   input  logic                  csr_write,
   input  csr_index_type         csr_index,
   input  logic [COEF_W-1:0]     csr_wdata,
   output int                    outstanding,
   output int                    failures
);

   localparam int     FRAC      = 46 - DATA_WIDTH;
   localparam int     OUT_SHIFT = FRAC + 12;
   localparam longint K_Q40     = 64'sd667681663058;
   localparam longint K_START   =
      (K_Q40 + (longint'(1) <<< (39 - FRAC))) >>> (40 - FRAC);

   // atan(2^-i) with a full turn at 2^32
   localparam longint ROT_ANGLE [24] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81
   };

   logic [COEF_W-1:0] radius_q;
   logic [COEF_W-1:0] inv_radius_q;
   rsp_type           expected_q [$];
   int                fail_count;

   // Round half up to Q8.8, then clamp to the result width
   function automatic logic signed [DATA_WIDTH-1:0] round_clamp(input longint acc,
                                                                 inout logic clip);
      longint r;
      r = (acc + (longint'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
      if (r > 32767) begin
         r    = 32767;
         clip = 1'b1;
      end else if (r < -32768) begin
         r    = -32768;
         clip = 1'b1;
      end
      return r[DATA_WIDTH-1:0];
   endfunction

   function automatic rsp_type matrix_product(input req_type item,
                                              input logic [COEF_W-1:0] rad,
                                              input logic [COEF_W-1:0] inv_rad);
      longint  angle, px, py, pz, dx, dy, cosv, sinv, a1, a2, acc1, acc2;
      logic    flip;
      logic    clip;
      rsp_type res;
      angle = longint'(item.heading);
      a1    = longint'(item.vec_first);
      a2    = longint'(item.vec_second);
      flip  = 1'b0;
      clip  = 1'b0;
      // fold into [-pi/2, pi/2]; the folded vector is negated afterwards
      if (angle > 16384) begin
         angle = angle - 32768;
         flip  = 1'b1;
      end else if (angle < -16384) begin
         angle = angle + 32768;
         flip  = 1'b1;
      end
      pz = angle * 65536;
      px = K_START;
      py = 0;
      for (int i = 0; i < STAGES && i < 24; i++) begin
         dx = py >>> i;
         dy = px >>> i;
         if (pz >= 0) begin
            px = px - dx;
            py = py + dy;
            pz = pz - ROT_ANGLE[i];
         end else begin
            px = px + dx;
            py = py - dy;
            pz = pz + ROT_ANGLE[i];
         end
      end
      cosv = flip ? -px : px;
      sinv = flip ? -py : py;
      if (item.opcode == OP_FORWARD) begin
         acc1 = cosv * a1 * 4096 - longint'(rad) * (sinv * a2);
         acc2 = sinv * a1 * 4096 + longint'(rad) * (cosv * a2);
      end else begin
         acc1 = (cosv * a1 + sinv * a2) * 4096;
         acc2 = (cosv * a2 - sinv * a1) * longint'(inv_rad);
      end
      res.res_first  = round_clamp(acc1, clip);
      res.res_second = round_clamp(acc2, clip);
      res.clipped    = clip;
      return res;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         radius_q     <= RADIUS_RESET;
         inv_radius_q <= INV_RADIUS_RESET;
         expected_q.delete();
         fail_count   = 0;
         outstanding  <= 0;
         failures     <= 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_RADIUS:     radius_q     <= csr_wdata;
               CSR_INV_RADIUS: inv_radius_q <= csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_q.push_back(matrix_product(req_payload, radius_q, inv_radius_q));
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $error("unexpected result item: res_first %0d res_second %0d clipped %0d",
                      rsp_payload.res_first, rsp_payload.res_second, rsp_payload.clipped);
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_payload.res_first !== want.res_first) begin
                  $error("res_first: expected %0d, actual %0d",
                         want.res_first, rsp_payload.res_first);
                  fail_count++;
               end
               if (rsp_payload.res_second !== want.res_second) begin
                  $error("res_second: expected %0d, actual %0d",
                         want.res_second, rsp_payload.res_second);
                  fail_count++;
               end
               if (rsp_payload.clipped !== want.clipped) begin
                  $error("clipped: expected %0d, actual %0d",
                         want.clipped, rsp_payload.clipped);
                  fail_count++;
               end
            end
         end
         outstanding <= expected_q.size();
         failures    <= fail_count;
      end
   end

endmodule

// ===== tb/testbench.sv =====
module testbench;
   import ufl_pkg::*;

   localparam int CYCLE_LIMIT  = 100000;
   localparam int HOLD_CYCLES  = 200;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 130;
   localparam int DRAIN_CYCLES = CORDIC_STAGES_DEFAULT + 10;

   localparam logic signed [DATA_WIDTH-1:0] EDGE_VALUES [5] = '{32767, -32768, 0, 1, -1};
   localparam logic signed [HEAD_W-1:0]     EDGE_ANGLES [7] =
      '{0, 16384, -16384, 32767, -32768, 16385, -16385};

   // Radius / reciprocal per phase; a negative entry means draw at random
   localparam int PHASE_RADIUS [PHASES] = '{0, 65535, 4096, 1229, -1, -1, 1, 2048};
   localparam int PHASE_INV    [PHASES] = '{65535, 0, 4096, 13653, -1, -1, 65535, 8192};
   // Idling mode per phase: sender idle percent and receiver stall percent
   localparam int PHASE_IDLE   [4] = '{0, 49, 0, 38};
   localparam int PHASE_STALL  [4] = '{0, 0, 49, 38};

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   req_type           req_payload;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_payload;
   logic              csr_write;
   csr_index_type     csr_index;
   logic [COEF_W-1:0] csr_wdata;

   logic              rsp_hold = 1'b0;
   int                send_idle_pct = 0;
   int                recv_stall_pct = 0;
   int                outstanding;
   int                failures;
   int                cycle_count = 0;

   unicycle_feedback_linearization_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   ufl_result_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .outstanding (outstanding),
      .failures    (failures)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Watchdog: end the run if the block hangs or results go missing
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Receiver: stall at random at the phase's rate; block fully while held off
   always @(posedge clock) begin
      rsp_ready <= !rsp_hold && ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic req_type make_req(input opcode_type op,
                                        input logic signed [HEAD_W-1:0] head,
                                        input logic signed [DATA_WIDTH-1:0] v1,
                                        input logic signed [DATA_WIDTH-1:0] v2);
      req_type item;
      item.opcode     = op;
      item.heading    = head;
      item.vec_first  = v1;
      item.vec_second = v2;
      return item;
   endfunction

   // Mostly full-range components, with small values and extremes mixed in
   function automatic logic signed [DATA_WIDTH-1:0] pick_component();
      int pick;
      pick = $urandom_range(9);
      if (pick < 6)
         return DATA_WIDTH'($urandom);
      if (pick < 8)
         return DATA_WIDTH'($signed($urandom_range(2047)) - 1024);
      if (pick == 8)
         return EDGE_VALUES[$urandom_range(4)];
      return DATA_WIDTH'($signed($urandom_range(16)) - 8);
   endfunction

   // Offer one item; hold valid and payload until the block takes it.
   // Valid only drops when an idle gap is inserted, so back-to-back items keep it high.
   task automatic send_item(input req_type item);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stop offering items and wait until every expected result has come back.
   // The first edge lets the checker's count catch up with the last accept.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Write both registers back to back while the block is empty
   task automatic set_radius(input logic [COEF_W-1:0] rad, input logic [COEF_W-1:0] inv_rad);
      drain_results();
      csr_write <= 1'b1;
      csr_index <= CSR_RADIUS;
      csr_wdata <= rad;
      @(posedge clock);
      csr_index <= CSR_INV_RADIUS;
      csr_wdata <= inv_rad;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   initial begin
      int      mode;
      int      rad;
      int      inv_rad;
      req_type item;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_write   = 1'b0;
      csr_index   = CSR_RADIUS;
      csr_wdata   = '0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed items under the reset radius: quadrant edges, folding at
      // plus and minus pi, extremes of the vector, and saturation in both modes
      send_item(make_req(OP_INVERSE, 0, 256, 0));
      send_item(make_req(OP_FORWARD, 0, 256, 256));
      send_item(make_req(OP_INVERSE, 16384, 256, 512));
      send_item(make_req(OP_FORWARD, -16384, -512, 256));
      send_item(make_req(OP_INVERSE, 16385, 1000, -1000));
      send_item(make_req(OP_FORWARD, -16385, -1000, 1000));
      send_item(make_req(OP_INVERSE, 32767, 256, 256));
      send_item(make_req(OP_INVERSE, -32768, 256, 256));
      send_item(make_req(OP_FORWARD, -32768, 256, -256));
      send_item(make_req(OP_FORWARD, 32767, 256, -256));
      send_item(make_req(OP_INVERSE, 8192, 32767, 32767));
      send_item(make_req(OP_INVERSE, 0, -32768, 32767));
      send_item(make_req(OP_FORWARD, 8192, 32767, -32768));
      send_item(make_req(OP_FORWARD, -32768, -32768, -32768));
      send_item(make_req(OP_INVERSE, -8192, -32768, -32768));
      send_item(make_req(OP_INVERSE, 0, 0, 0));
      send_item(make_req(OP_FORWARD, 1, 1, -1));
      send_item(make_req(OP_INVERSE, -1, -1, 1));
      send_item(make_req(OP_FORWARD, 12345, 32767, 32767));
      send_item(make_req(OP_INVERSE, -20000, 1, 1));

      // Random phases: each with its own register setting and idling mode
      for (int phase = 0; phase < PHASES; phase++) begin
         rad     = (PHASE_RADIUS[phase] < 0) ? $urandom_range(65535) : PHASE_RADIUS[phase];
         inv_rad = (PHASE_INV[phase] < 0) ? $urandom_range(65535) : PHASE_INV[phase];
         set_radius(COEF_W'(rad), COEF_W'(inv_rad));
         mode           = phase % 4;
         send_idle_pct  = PHASE_IDLE[mode];
         recv_stall_pct = PHASE_STALL[mode];
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Hold the receiver off for a long stretch while items keep coming,
            // so the pipeline fills and the input side has to stall
            if (phase == 0 && n == 30) begin
               fork
                  begin
                     rsp_hold <= 1'b1;
                     repeat (HOLD_CYCLES) @(posedge clock);
                     rsp_hold <= 1'b0;
                  end
               join_none
            end
            item.opcode     = opcode_type'($urandom_range(1));
            item.heading    = ($urandom_range(9) == 0) ? EDGE_ANGLES[$urandom_range(6)]
                                                       : HEAD_W'($urandom);
            item.vec_first  = pick_component();
            item.vec_second = pick_component();
            send_item(item);
         end
      end

      drain_results();
      // Give any stray result time to show up before the verdict
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
